### rtl/oblu_pkg.sv
package oblu_pkg;
    localparam int LEVELS = 8;
    localparam int CNT_W = $clog2(LEVELS + 1);

    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;

    typedef struct packed {
        logic        apply;    // apply staged event, update book
        logic        load_out; // capture result into output register
    } t_cmd;

    typedef struct packed {
        logic [1:0]  op;
        logic        side;
        logic [31:0] instrument;
        logic [31:0] price;
        logic [31:0] size;
    } t_event;

    typedef struct packed {
        logic        top_valid;
        logic [31:0] best_bid_price;
        logic [31:0] best_bid_size;
        logic [31:0] best_ask_price;
        logic [31:0] best_ask_size;
        logic [31:0] book_instrument;
        logic [31:0] events_applied;
    } t_result;
endpackage

### rtl/oblu_side.sv
module oblu_side (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_apply,
    input  logic        i_is_bid,
    input  logic [31:0] i_price,
    input  logic [31:0] i_size,
    output logic [31:0] o_top_price,
    output logic [31:0] o_top_size,
    output logic        o_nonempty
);
    import oblu_pkg::*;

    logic [31:0]      r_pr [LEVELS];
    logic [31:0]      r_sz [LEVELS];
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic [LEVELS-1:0] hit_v, ahead_v, valid_v;
    logic              any_hit, full;
    logic [LEVELS-1:0] rm_from, ins_from;
    logic [31:0] n_pr [LEVELS];
    logic [31:0] n_sz [LEVELS];

    // per-level compares, all in parallel
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            valid_v[i] = CNT_W'(i) < r_used;
            hit_v[i]   = valid_v[i] && (r_pr[i] == i_price);
            ahead_v[i] = i_is_bid ? ($signed(i_price) > $signed(r_pr[i]))
                                  : ($signed(i_price) < $signed(r_pr[i]));
        end
    end

    assign any_hit = |hit_v;
    assign full    = (r_used == CNT_W'(LEVELS));

    // thermometer masks: level i at or after the hit / insert point
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            rm_from[i]  = (i == 0) ? hit_v[0] : (rm_from[i-1] | hit_v[i]);
            ins_from[i] = (i == 0) ? ~valid_v[0] | ahead_v[0]
                                   : (ins_from[i-1] | ~valid_v[i] | ahead_v[i]);
        end
    end

    always_comb begin
        n_used = r_used;
        for (int i = 0; i < LEVELS; i++) begin
            n_pr[i] = r_pr[i];
            n_sz[i] = r_sz[i];
        end
        if (i_size == 32'd0) begin
            if (any_hit) begin
                for (int i = 0; i < LEVELS - 1; i++) begin
                    if (rm_from[i]) begin
                        n_pr[i] = r_pr[i+1];
                        n_sz[i] = r_sz[i+1];
                    end
                end
                n_used = r_used - CNT_W'(1);
            end
        end else if (any_hit) begin
            for (int i = 0; i < LEVELS; i++)
                if (hit_v[i]) n_sz[i] = i_size;
        end else if (!(full && !ahead_v[LEVELS-1])) begin
            for (int i = 0; i < LEVELS; i++) begin
                if (ins_from[i]) begin
                    if (i == 0 || !ins_from[i-1]) begin
                        n_pr[i] = i_price;
                        n_sz[i] = i_size;
                    end else begin
                        n_pr[i] = r_pr[i-1];
                        n_sz[i] = r_sz[i-1];
                    end
                end
            end
            if (!full) n_used = r_used + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_pr[i] <= n_pr[i];
                r_sz[i] <= n_sz[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_apply) begin
            r_used <= n_used;
        end
    end

    assign o_top_price = r_pr[0];
    assign o_top_size  = r_sz[0];
    assign o_nonempty  = (r_used != '0);
endmodule

### rtl/oblu_datapath.sv
module oblu_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  oblu_pkg::t_cmd  i_cmd,
    input  oblu_pkg::t_event i_event,
    output oblu_pkg::t_result o_result
);
    import oblu_pkg::*;

    t_event      r_ev;
    logic [31:0] r_instr, r_total;
    logic [31:0] bid_p, bid_s, ask_p, ask_s;
    logic        bid_ne, ask_ne, is_book_op, top;

    // stage the event so the level compares start from a register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out == 1'b0 && i_cmd.apply == 1'b0) r_ev <= i_event;
    end

    assign is_book_op = (r_ev.op == OP_SET) || (r_ev.op == OP_DEL);

    oblu_side u_bid (
        .i_clk, .i_rst_n,
        .i_apply (i_cmd.apply && is_book_op && !r_ev.side),
        .i_is_bid(1'b1),
        .i_price (r_ev.price),
        .i_size  ((r_ev.op == OP_DEL) ? 32'd0 : r_ev.size),
        .o_top_price(bid_p), .o_top_size(bid_s), .o_nonempty(bid_ne)
    );

    oblu_side u_ask (
        .i_clk, .i_rst_n,
        .i_apply (i_cmd.apply && is_book_op && r_ev.side),
        .i_is_bid(1'b0),
        .i_price (r_ev.price),
        .i_size  ((r_ev.op == OP_DEL) ? 32'd0 : r_ev.size),
        .o_top_price(ask_p), .o_top_size(ask_s), .o_nonempty(ask_ne)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr <= '0;
            r_total <= '0;
        end else if (i_cmd.apply) begin
            r_instr <= r_ev.instrument;
            r_total <= r_total + 32'd1;
        end
    end

    assign top = bid_ne && ask_ne;
    assign o_result.top_valid       = top;
    assign o_result.best_bid_price  = top ? bid_p : 32'd0;
    assign o_result.best_bid_size   = top ? bid_s : 32'd0;
    assign o_result.best_ask_price  = top ? ask_p : 32'd0;
    assign o_result.best_ask_size   = top ? ask_s : 32'd0;
    assign o_result.book_instrument = r_instr;
    assign o_result.events_applied  = r_total;
endmodule

### rtl/oblu_ctrl.sv
module oblu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output oblu_pkg::t_cmd o_cmd
);
    import oblu_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // input is free in IDLE; output register holds one result independently
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_APPLY;
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_LOAD && !(!r_out_valid || i_out_ready)) o_cmd.load_out = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### rtl/order_book_level_update.sv
// Price-level order book for one instrument, eight levels per side.
// Input channel s_axis: one beat is one market event (op, side,
// instrument, price, size). Output channel m_axis: one beat per event,
// the top of book after that event, plus the last instrument and a
// wrapping event count.
// Path: an accepted beat is staged in the event register, applied to the
// level registers and then loaded into the output register once free.
// Events are taken one at a time; the shift-insert across all levels
// of one side, done by parallel compares, is the apply step. The input
// is taken again as soon as the result is in the output register.
// Stall: while m_axis_tready is low the output register holds its beat;
// a following event is staged and applied but waits in the load step.
// Reset (i_rst_n low, synchronous): both sides empty, counters and the
// instrument cleared, no output beat pending. Level contents are not
// cleared; only levels below each side's used count are ever read.
module order_book_level_update (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // op[1:0], side[2], instrument[34:3], price[66:35], size[98:67], zero pad
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // top_valid[0], best_bid_price[32:1], best_bid_size[64:33],
    // best_ask_price[96:65], best_ask_size[128:97],
    // book_instrument[160:129], events_applied[192:161], zero pad
    output logic [199:0]  m_axis_tdata
);
    import oblu_pkg::*;

    t_cmd    cmd;
    t_event  ev;
    t_result res, r_res;

    assign ev.op         = s_axis_tdata[1:0];
    assign ev.side       = s_axis_tdata[2];
    assign ev.instrument = s_axis_tdata[34:3];
    assign ev.price      = s_axis_tdata[66:35];
    assign ev.size       = s_axis_tdata[98:67];

    oblu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (cmd)
    );

    oblu_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd   (cmd),
        .i_event (ev),
        .o_result(res)
    );

    // output register: hold the beat until it is taken
    always_ff @(posedge i_clk) begin
        if (cmd.load_out) r_res <= res;
    end

    assign m_axis_tdata = {7'd0, r_res.events_applied, r_res.book_instrument,
                           r_res.best_ask_size, r_res.best_ask_price,
                           r_res.best_bid_size, r_res.best_bid_price,
                           r_res.top_valid};

`ifndef ASSERT_OFF
    // the output register never loads over an untaken beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten");
    // apply and load never coincide
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.apply && cmd.load_out))
        else $error("apply and load overlap");
    // an accepted beat is applied in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.apply)
        else $error("accepted event not applied");
`endif
endmodule

### tb/order_book_level_update_tb.sv
module order_book_level_update_tb;
    import oblu_pkg::*;

    localparam int NUM_RANDOM = 800;
    localparam logic [1:0] OP_TRADE = 2'd2;
    localparam logic [1:0] OP_ODD   = 2'd3;

    // Top-of-book expectations built from a private copy of both book sides.
    class book_scoreboard;
        logic [31:0] bid_px[LEVELS];
        logic [31:0] bid_sz[LEVELS];
        logic [31:0] ask_px[LEVELS];
        logic [31:0] ask_sz[LEVELS];
        int          bid_cnt;
        int          ask_cnt;
        logic [31:0] last_instr;
        logic [31:0] event_cnt;
        t_result     pending_tops[$];
        int          mismatches;
        int          matched;

        function new();
            bid_cnt    = 0;
            ask_cnt    = 0;
            last_instr = '0;
            event_cnt  = '0;
            mismatches = 0;
            matched    = 0;
        endfunction

        // Strictly better price for the side: higher for bids, lower for asks.
        function bit better(logic [31:0] a, logic [31:0] b, bit is_bid);
            if (is_bid) return $signed(a) > $signed(b);
            return $signed(a) < $signed(b);
        endfunction

        function void update_side(ref logic [31:0] px[LEVELS], ref logic [31:0] sz[LEVELS],
                                  ref int cnt, input logic [31:0] price,
                                  input logic [31:0] qty, input bit is_bid);
            int hit;
            int pos;
            int n;
            n   = cnt;
            hit = n;
            for (int i = 0; i < n; i++)
                if (px[i] == price && hit == n) hit = i;
            if (qty == 0) begin
                if (hit >= n) return;
                for (int i = hit; i + 1 < n; i++) begin
                    px[i] = px[i+1];
                    sz[i] = sz[i+1];
                end
                cnt = n - 1;
                return;
            end
            if (hit < n) begin
                sz[hit] = qty;
                return;
            end
            if (n == LEVELS) begin
                // full side: drop unless better than the worst level
                if (!better(price, px[n-1], is_bid)) return;
                n--;
            end
            pos = n;
            for (int i = n - 1; i >= 0; i--)
                if (better(price, px[i], is_bid)) pos = i;
            for (int i = n; i > pos; i--) begin
                px[i] = px[i-1];
                sz[i] = sz[i-1];
            end
            px[pos] = price;
            sz[pos] = qty;
            cnt = n + 1;
        endfunction

        function void note_event(t_event ev);
            t_result r;
            logic [31:0] qty;
            last_instr = ev.instrument;
            event_cnt  = event_cnt + 32'd1;
            if (ev.op == OP_SET || ev.op == OP_DEL) begin
                qty = (ev.op == OP_DEL) ? 32'd0 : ev.size;
                if (ev.side == 1'b0)
                    update_side(bid_px, bid_sz, bid_cnt, ev.price, qty, 1'b1);
                else
                    update_side(ask_px, ask_sz, ask_cnt, ev.price, qty, 1'b0);
            end
            r = '0;
            if (bid_cnt > 0 && ask_cnt > 0) begin
                r.top_valid      = 1'b1;
                r.best_bid_price = bid_px[0];
                r.best_bid_size  = bid_sz[0];
                r.best_ask_price = ask_px[0];
                r.best_ask_size  = ask_sz[0];
            end
            r.book_instrument = last_instr;
            r.events_applied  = event_cnt;
            pending_tops.push_back(r);
        endfunction

        function void check_top(t_result got);
            t_result want;
            if (pending_tops.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending_tops.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("top mismatch: exp v%0d bid %0d/%0d ask %0d/%0d ins %h n %0d | got v%0d bid %0d/%0d ask %0d/%0d ins %h n %0d",
                             want.top_valid, $signed(want.best_bid_price), want.best_bid_size,
                             $signed(want.best_ask_price), want.best_ask_size,
                             want.book_instrument, want.events_applied,
                             got.top_valid, $signed(got.best_bid_price), got.best_bid_size,
                             $signed(got.best_ask_price), got.best_ask_size,
                             got.book_instrument, got.events_applied);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata;  // op, side, instrument, price, size, zero pad
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [199:0]  m_axis_tdata;  // top_valid, bid px/sz, ask px/sz, instrument, count

    book_scoreboard sb;
    bit             quiet_tail;
    int             beats_sent;

    order_book_level_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Note events and check results on the same edge the handshakes fire.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_event(t_event'({s_axis_tdata[1:0], s_axis_tdata[2],
                                    s_axis_tdata[34:3], s_axis_tdata[66:35],
                                    s_axis_tdata[98:67]}));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_top(t_result'({m_axis_tdata[0], m_axis_tdata[32:1],
                                    m_axis_tdata[64:33], m_axis_tdata[96:65],
                                    m_axis_tdata[128:97], m_axis_tdata[160:129],
                                    m_axis_tdata[192:161]}));
        end
    end

    // Receiver stalls at random until the quiet tail.
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Present one event and hold it until taken; idle beforehand at random.
    task automatic send_event(logic [1:0] op, logic side, logic [31:0] instr,
                              logic [31:0] price, logic [31:0] qty);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, qty, price, instr, side, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Prices clustered near a mid so levels collide, fill and evict.
    function automatic logic [31:0] near_price(logic side);
        int base;
        base = side ? 1010 : 990;
        return base + $urandom_range(0, 24) - 12;
    endfunction

    task automatic random_event();
        logic [1:0]  op;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        int          pick;
        pick  = $urandom_range(0, 99);
        side  = 1'($urandom_range(0, 1));
        price = ($urandom_range(0, 19) == 0) ? $urandom() : near_price(side);
        qty   = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
        if (pick < 65)      op = OP_SET;
        else if (pick < 85) op = OP_DEL;
        else if (pick < 95) op = OP_TRADE;
        else                op = OP_ODD;
        send_event(op, side, $urandom(), price, qty);
    endtask

    initial begin
        int waited;
        sb            = new();
        quiet_tail    = 1'b0;
        beats_sent    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty sides, extreme fields, odd op, missing delete.
        send_event(OP_TRADE, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_event(OP_SET, 1'b0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_event(OP_SET, 1'b1, 32'h1234_5678, 32'h7FFF_FFFF, 32'd1);
        send_event(OP_ODD, 1'b1, 32'hA5A5_A5A5, 32'd5, 32'd5);
        send_event(OP_DEL, 1'b1, 32'd1, 32'd77, 32'd0);
        send_event(OP_SET, 1'b0, 32'd2, 32'h8000_0000, 32'd9);
        send_event(OP_SET, 1'b0, 32'd3, 32'h8000_0000, 32'd0);
        send_event(OP_DEL, 1'b1, 32'd4, 32'h7FFF_FFFF, 32'd3);
        // Fill the bid side past capacity: worse prices get dropped, an equal price updates its size.
        for (int i = 0; i < 9; i++)
            send_event(OP_SET, 1'b0, i, 100 + 2 * i, 1000 + i);
        send_event(OP_SET, 1'b0, 32'd20, 32'd102, 32'd7);
        send_event(OP_SET, 1'b0, 32'd21, 32'd50, 32'd7);
        send_event(OP_SET, 1'b0, 32'd22, 32'd117, 32'd7);
        send_event(OP_SET, 1'b1, 32'd23, 32'hFFFF_FFFF, 32'd8);
        send_event(OP_DEL, 1'b0, 32'd24, 32'd110, 32'd0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - 100) quiet_tail = 1'b1;
            random_event();
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_tops.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d book events (set, delete, trade, odd op, full-side cases);",
                 beats_sent);
        $display("%0d top-of-book beats matched, %0d mismatches.", sb.matched, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_tops.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending_tops.size() != 0)
                $display("%0d expected beats never arrived", sb.pending_tops.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting for the block");
        $display("== FAIL ==");
        $finish;
    end
endmodule
